// File: rtl/core/pstd_pkg.sv
// Shared types, register codes and reset values for the per-source rate and scan detector.
// No dependencies; the top level, front and back parts import this package.
package pstd_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	// configuration register indexes
	localparam logic [1:0] REG_PPS_LIMIT   = 2'd0;
	localparam logic [1:0] REG_BPS_LIMIT   = 2'd1;
	localparam logic [1:0] REG_PORTS_LIMIT = 2'd2;
	localparam logic [1:0] REG_WINDOW_LEN  = 2'd3;

	localparam logic [31:0] PPS_LIMIT_RST   = 32'd10000;
	localparam logic [47:0] BPS_LIMIT_RST   = 48'd104857600;
	localparam logic [31:0] PORTS_LIMIT_RST = 32'd50;
	localparam logic [39:0] WINDOW_LEN_RST  = 40'd1000000000;

	// alert kinds
	localparam logic [1:0] KIND_PPS  = 2'd0;
	localparam logic [1:0] KIND_BPS  = 2'd1;
	localparam logic [1:0] KIND_SCAN = 2'd2;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	typedef struct packed {
		logic [31:0] pps_limit;
		logic [47:0] bps_limit;
		logic [31:0] ports_limit;
		logic [39:0] win_len;
	} cfg_t;

	typedef struct packed {
		logic [31:0] src;
		logic [63:0] now;
		logic [31:0] len;
		logic        has_port;
	} cmd_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] prate;
		logic [63:0] brate;
		logic [31:0] scount;
		logic [1:0]  kind;
		logic [63:0] atime;
		logic        last;
	} alert_t;

	typedef struct packed {
		logic        rv;
		logic        sv;
		logic [31:0] tag;
		logic [63:0] rstart;
		logic [31:0] pc;
		logic [63:0] bt;
		logic [63:0] sstart;
		logic [31:0] phc;
		logic        sal;
	} entry_t;

endpackage

// File: rtl/core/per_source_rate_and_scan_detector.sv
// Top level of the per-source rate and scan detector: configuration registers,
// front part, command queue, back part and result queue. Uses pstd_pkg and all pstd_ modules.
//
//  channel   handshake              payload
//  input     push / full            source_address .. destination_port
//  result    pop / empty            alert_source .. last_alert
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The back part reads, compares and writes the entry for each packet, then emits each
// alert it raises; it takes no new packet until done with the last. The front registers
// each packet in stages s1 and s2. After reset the table is cleared one entry a cycle,
// all TABLE_ENTRIES entries, with full high. Config writes are taken every cycle. A
// stalled result queue holds the back part; the command queue then fills and raises full.
module per_source_rate_and_scan_detector import pstd_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] source_address,
	input  logic [63:0] now_ns,
	input  logic [31:0] packet_length,
	input  logic        ip_header_ok,
	input  logic [7:0]  protocol,
	input  logic        l4_header_ok,
	input  logic [15:0] destination_port,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] alert_source,
	output logic [31:0] packet_rate,
	output logic [63:0] window_bytes,
	output logic [31:0] scan_count,
	output logic [1:0]  alert_kind,
	output logic [63:0] alert_time,
	output logic        last_alert,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(CMD_DEPTH + 1);

	cfg_t          cfg_q;
	logic          cmd_wr, cmd_rd, cmd_empty, cmd_full;
	cmd_t          cmd_w, cmd_r;
	logic [IW-1:0] idx_w, idx_r;
	logic [CW-1:0] cmd_cnt;
	logic [1:0]    in_flight;
	logic          res_wr, res_full, res_empty, clearing;
	alert_t        res_w, res_r;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pps_limit   <= PPS_LIMIT_RST;
			cfg_q.bps_limit   <= BPS_LIMIT_RST;
			cfg_q.ports_limit <= PORTS_LIMIT_RST;
			cfg_q.win_len     <= WINDOW_LEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PPS_LIMIT:   cfg_q.pps_limit   <= cfg_data[31:0];
				REG_BPS_LIMIT:   cfg_q.bps_limit   <= cfg_data;
				REG_PORTS_LIMIT: cfg_q.ports_limit <= cfg_data[31:0];
				REG_WINDOW_LEN:  cfg_q.win_len     <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	// reserve queue room for items still in the front stages
	assign full = clearing || cmd_full
		|| ((CW+1)'(cmd_cnt) + (CW+1)'(in_flight) >= (CW+1)'(CMD_DEPTH));

	pstd_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (push && !full),
		.source_address   (source_address),
		.now_ns           (now_ns),
		.packet_length    (packet_length),
		.ip_header_ok     (ip_header_ok),
		.protocol         (protocol),
		.l4_header_ok     (l4_header_ok),
		.destination_port (destination_port),
		.cmd_wr           (cmd_wr),
		.cmd              (cmd_w),
		.cmd_idx          (idx_w),
		.in_flight        (in_flight)
	);

	pstd_fifo #(.WIDTH($bits(cmd_t) + IW), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  ({cmd_w, idx_w}),
		.rd     (cmd_rd),
		.rdata  ({cmd_r, idx_r}),
		.empty  (cmd_empty),
		.full   (cmd_full),
		.count  (cmd_cnt)
	);

	pstd_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_r),
		.cmd_idx   (idx_r),
		.cmd_rd    (cmd_rd),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res       (res_w),
		.clearing  (clearing)
	);

	pstd_fifo #(.WIDTH($bits(alert_t)), .DEPTH(RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_w),
		.rd     (pop),
		.rdata  (res_r),
		.empty  (res_empty),
		.full   (res_full),
		.count  ()
	);

	// present the oldest alert
	assign empty        = res_empty;
	assign alert_source = res_r.src;
	assign packet_rate  = res_r.prate;
	assign window_bytes = res_r.brate;
	assign scan_count   = res_r.scount;
	assign alert_kind   = res_r.kind;
	assign alert_time   = res_r.atime;
	assign last_alert   = res_r.last;

endmodule

// File: rtl/core/pstd_fifo.sv
// Small register-based queue used between front and back and on the result side.
// Depends on nothing; width and depth come from the instantiating module.
module pstd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       rd,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign count = cnt_q;
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// hold storage, store on an accepted write
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/core/pstd_front.sv
// Front part: accepts packets, drops those without an IP header, classifies the port
// and computes the table index (address modulo table size). Uses pstd_pkg.
module pstd_front import pstd_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  logic [31:0]                      source_address,
	input  logic [63:0]                      now_ns,
	input  logic [31:0]                      packet_length,
	input  logic                             ip_header_ok,
	input  logic [7:0]                       protocol,
	input  logic                             l4_header_ok,
	input  logic [15:0]                      destination_port,
	output logic                             cmd_wr,
	output cmd_t                             cmd,
	output logic [$clog2(TABLE_ENTRIES)-1:0] cmd_idx,
	output logic [1:0]                       in_flight
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int SH = 32 + IW;
	localparam logic [63:0] RECIP = (64'd1 << SH) / TABLE_ENTRIES;
	localparam int MW = SH - IW + 2;

	logic          v_s1, v_s2;
	cmd_t          cmd_s1, cmd_s2;
	logic [MW+31:0] prod_s1;
	logic [32:0]   rem_s2;
	logic [31:0]   quo;
	logic [63:0]   qn;

	assign quo = 32'(prod_s1 >> SH);
	assign qn  = 64'(quo) * 64'(TABLE_ENTRIES);

	// advance valid bits; the queue reserves room for items in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take && ip_header_ok;
			v_s2 <= v_s1;
		end
	end

	// classify and multiply by reciprocal, then take the remainder estimate
	always_ff @(posedge clk) begin
		cmd_s1.src      <= source_address;
		cmd_s1.now      <= now_ns;
		cmd_s1.len      <= packet_length;
		cmd_s1.has_port <= (protocol == PROTO_TCP || protocol == PROTO_UDP)
			&& l4_header_ok && (destination_port != 16'd0);
		prod_s1 <= (MW+32)'(source_address) * (MW+32)'(RECIP[MW-1:0]);
		cmd_s2  <= cmd_s1;
		rem_s2  <= 33'(64'(cmd_s1.src) - qn);
	end

	// correct the remainder by one subtract
	assign cmd_wr  = v_s2;
	assign cmd     = cmd_s2;
	assign cmd_idx = (rem_s2 >= 33'(TABLE_ENTRIES)) ? IW'(rem_s2 - 33'(TABLE_ENTRIES))
		: IW'(rem_s2);
	assign in_flight = 2'(v_s1) + 2'(v_s2);

endmodule

// File: rtl/core/pstd_back.sv
// Back part: per-source table, read-modify-write of one entry per packet, alert emission.
// Uses pstd_pkg; clears the table after reset before taking commands.
module pstd_back import pstd_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfg_t                             cfg,
	input  logic                             cmd_empty,
	input  cmd_t                             cmd,
	input  logic [$clog2(TABLE_ENTRIES)-1:0] cmd_idx,
	output logic                             cmd_rd,
	input  logic                             res_full,
	output logic                             res_wr,
	output alert_t                           res,
	output logic                             clearing
);
	localparam int IW = $clog2(TABLE_ENTRIES);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_UPD   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	entry_t        mem [TABLE_ENTRIES];
	entry_t        rd_q;
	logic [2:0]    st_q;
	logic [IW-1:0] clr_q, idx_q;
	cmd_t          cur_q;
	logic          hit_q, rexp_q, sexp_q, pgt_q, bgt_q, hgt_q, h1gt_q;
	alert_t        al_q [3];
	logic [1:0]    n_q, e_q;

	logic          we;
	logic [IW-1:0] wa;
	entry_t        wd, ne;
	alert_t        tmp [3];
	logic [1:0]    cnt;
	logic          svv, sal_c, over;
	logic [31:0]   nh;

	assign clearing = (st_q == ST_CLEAR);
	assign cmd_rd   = (st_q == ST_IDLE) && !cmd_empty;

	// table write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd_rd) begin
			rd_q <= mem[cmd_idx];
		end
	end

	// compute the updated entry and the alerts it raises
	always_comb begin
		ne    = rd_q;
		cnt   = 2'd0;
		nh    = 32'd1;
		sal_c = 1'b0;
		over  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			tmp[i] = '0;
		end
		svv = hit_q && rd_q.sv;
		if (hit_q) begin
			if (rexp_q) begin
				if (pgt_q || bgt_q) begin
					tmp[0].src   = cur_q.src;
					tmp[0].prate = rd_q.pc;
					tmp[0].brate = rd_q.bt;
					tmp[0].kind  = pgt_q ? KIND_PPS : KIND_BPS;
					tmp[0].atime = cur_q.now;
					cnt          = 2'd1;
				end
				ne.rstart = cur_q.now;
				ne.pc     = 32'd1;
				ne.bt     = 64'(cur_q.len);
			end else begin
				ne.pc = rd_q.pc + 32'd1;
				ne.bt = rd_q.bt + 64'(cur_q.len);
			end
		end else begin
			ne.rv     = 1'b1;
			ne.sv     = 1'b0;
			ne.tag    = cur_q.src;
			ne.rstart = cur_q.now;
			ne.pc     = 32'd1;
			ne.bt     = 64'(cur_q.len);
		end
		if (cur_q.has_port) begin
			if (svv) begin
				if (sexp_q) begin
					if (!rd_q.sal && hgt_q) begin
						tmp[cnt].src    = cur_q.src;
						tmp[cnt].scount = rd_q.phc;
						tmp[cnt].kind   = KIND_SCAN;
						tmp[cnt].atime  = cur_q.now;
						cnt             = cnt + 2'd1;
					end
					nh        = 32'd1;
					sal_c     = 1'b0;
					over      = (cfg.ports_limit == 32'd0);
					ne.sstart = cur_q.now;
				end else begin
					nh    = rd_q.phc + 32'd1;
					sal_c = rd_q.sal;
					over  = h1gt_q;
				end
				ne.phc = nh;
				ne.sal = sal_c;
				if (over && !sal_c) begin
					tmp[cnt].src    = cur_q.src;
					tmp[cnt].scount = nh;
					tmp[cnt].kind   = KIND_SCAN;
					tmp[cnt].atime  = cur_q.now;
					cnt             = cnt + 2'd1;
					ne.sal          = 1'b1;
				end
			end else begin
				ne.sv     = 1'b1;
				ne.sstart = cur_q.now;
				ne.phc    = 32'd1;
				ne.sal    = 1'b0;
			end
		end
	end

	// select the table write: clearing sweep or entry update
	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = ne;
		if (st_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (st_q == ST_UPD) begin
			we = 1'b1;
		end
	end

	// drive the current alert toward the result queue
	always_comb begin
		res      = al_q[e_q];
		res.last = (e_q == n_q - 2'd1);
		res_wr   = (st_q == ST_EMIT) && !res_full;
	end

	// latch the command, the window and limit compares, and the alerts
	always_ff @(posedge clk) begin
		if (cmd_rd) begin
			cur_q <= cmd;
			idx_q <= cmd_idx;
		end
		if (st_q == ST_EVAL) begin
			hit_q  <= rd_q.rv && (rd_q.tag == cur_q.src);
			rexp_q <= (cur_q.now - rd_q.rstart) >= 64'(cfg.win_len);
			sexp_q <= (cur_q.now - rd_q.sstart) >= 64'(cfg.win_len);
			pgt_q  <= rd_q.pc > cfg.pps_limit;
			bgt_q  <= rd_q.bt > 64'(cfg.bps_limit);
			hgt_q  <= rd_q.phc > cfg.ports_limit;
			h1gt_q <= (rd_q.phc + 32'd1) > cfg.ports_limit;
		end
		if (st_q == ST_UPD) begin
			for (int i = 0; i < 3; i++) begin
				al_q[i] <= tmp[i];
			end
			n_q <= cnt;
		end
	end

	// sequence: clear, idle, evaluate, update, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLEAR;
			clr_q <= '0;
			e_q   <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(TABLE_ENTRIES - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!cmd_empty) begin
						st_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					e_q  <= '0;
					st_q <= (cnt == 2'd0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (!res_full) begin
						e_q <= e_q + 2'd1;
						if (e_q == n_q - 2'd1) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
